/* design/ngram_record_parser_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the n-gram record parser
// Shared property forms: same-cycle and next-cycle implication on clk/rst.
// ----------------------------------------------------------------------------
`ifndef NGRAM_RECORD_PARSER_TOP_ASSERT_SVH
`define NGRAM_RECORD_PARSER_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define NRP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define NRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/nrp_pkg.sv */
// ----------------------------------------------------------------------------
// nrp_pkg
// Types and constants shared by the n-gram record parser modules.
// ----------------------------------------------------------------------------
package nrp_pkg;

  localparam int WORDS_PER_RECORD_DEF = 5;
  localparam int VARINT_MAX_BYTES_DEF = 5;
  localparam int QUEUE_DEPTH_DEF      = 4;

  localparam int          CFG_W          = 16;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd16384;
  localparam int          ID_W           = 35;
  localparam int          SLOT_W         = 3;
  localparam int          HALF_W         = 16;
  localparam int          TDATA_W        = 72;   // 70 payload bits padded to bytes
  localparam int          TUSER_W        = 2;

  localparam logic [7:0]  PAYLOAD_MASK   = 8'h7F;
  localparam logic [7:0]  CONT_BIT       = 8'h80;

  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_EMPTY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_LEN_LO = 3'd0,
    PH_LEN_HI = 3'd1,
    PH_WORD   = 3'd2,
    PH_CNT_LO = 3'd3,
    PH_CNT_HI = 3'd4,
    PH_PAIR   = 3'd5,
    PH_SKIP   = 3'd6
  } phase_t;

  // One classified result between front and back. For a word, val holds the
  // raw varint accumulator; for a pair, val[31:16] is year, val[15:0] count.
  typedef struct packed {
    kind_t               kind;
    logic [SLOT_W-1:0]   slot;
    logic [ID_W-1:0]     val;
    logic                last;
  } q_item_t;

endpackage

/* design/nrp_front.sv */
// ----------------------------------------------------------------------------
// nrp_front
// Byte parser: walks the record framing and pushes classified results.
// ----------------------------------------------------------------------------
module nrp_front #(
  parameter int WORDS_PER_RECORD = nrp_pkg::WORDS_PER_RECORD_DEF,
  parameter int VARINT_MAX_BYTES = nrp_pkg::VARINT_MAX_BYTES_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  input  logic [7:0]                s_tdata,
  input  logic                      cfg_valid,
  input  logic [nrp_pkg::CFG_W-1:0] cfg_data,
  input  logic                      q_full,
  output logic                      push,
  output nrp_pkg::q_item_t          push_item
);
  import nrp_pkg::*;

  localparam int VB_W = $clog2(VARINT_MAX_BYTES + 1);

  logic [CFG_W-1:0]  max_record_len;
  phase_t            phase, phase_next;
  logic [15:0]       bytes_left, bytes_left_next;
  logic [7:0]        low_byte_hold, low_byte_hold_next;
  logic [ID_W-1:0]   varint_accum, varint_accum_next;
  logic [VB_W-1:0]   varint_bytes, varint_bytes_next;
  logic [SLOT_W-1:0] slot_index, slot_index_next;
  logic [15:0]       pairs_left, pairs_left_next;
  logic [15:0]       year_hold, year_hold_next;
  logic [1:0]        pair_byte_pos, pair_byte_pos_next;

  logic accept;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_record_len <= MAX_LEN_RESET;
      phase          <= PH_LEN_LO;
      bytes_left     <= '0;
      low_byte_hold  <= '0;
      varint_accum   <= '0;
      varint_bytes   <= '0;
      slot_index     <= '0;
      pairs_left     <= '0;
      year_hold      <= '0;
      pair_byte_pos  <= '0;
    end else begin
      if (cfg_valid) max_record_len <= cfg_data;
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      low_byte_hold <= low_byte_hold_next;
      varint_accum  <= varint_accum_next;
      varint_bytes  <= varint_bytes_next;
      slot_index    <= slot_index_next;
      pairs_left    <= pairs_left_next;
      year_hold     <= year_hold_next;
      pair_byte_pos <= pair_byte_pos_next;
    end
  end

  always_comb begin
    logic [15:0]     len;
    logic [15:0]     bl_dec;
    logic [15:0]     pairs_dec;
    logic [ID_W-1:0] acc_new;
    logic            done;
    logic            body;

    len       = {s_tdata, low_byte_hold};
    bl_dec    = bytes_left - 16'd1;
    pairs_dec = pairs_left - 16'd1;
    acc_new   = {varint_accum[ID_W-8:0], s_tdata[6:0] & PAYLOAD_MASK[6:0]};
    done      = 1'b0;
    body      = 1'b0;

    phase_next         = phase;
    bytes_left_next    = bytes_left;
    low_byte_hold_next = low_byte_hold;
    varint_accum_next  = varint_accum;
    varint_bytes_next  = varint_bytes;
    slot_index_next    = slot_index;
    pairs_left_next    = pairs_left;
    year_hold_next     = year_hold;
    pair_byte_pos_next = pair_byte_pos;
    push               = 1'b0;
    push_item          = '0;

    if (accept) begin
      case (phase)
        PH_LEN_HI: begin
          bytes_left_next = len;
          if (len > max_record_len) begin
            push            = 1'b1;
            push_item.kind  = KIND_ERROR;
            push_item.last  = 1'b1;
            phase_next      = PH_SKIP;     // over-limit length is never zero
          end else if (len == 16'd0) begin
            push            = 1'b1;
            push_item.kind  = KIND_ERROR;
            push_item.last  = 1'b1;
            phase_next      = PH_LEN_LO;
          end else begin
            varint_accum_next  = '0;
            varint_bytes_next  = '0;
            slot_index_next    = '0;
            pair_byte_pos_next = '0;
            phase_next         = PH_WORD;
          end
        end
        PH_SKIP: begin
          bytes_left_next = bl_dec;
          if (bl_dec == 16'd0) phase_next = PH_LEN_LO;
        end
        PH_WORD: begin
          body = 1'b1;
          if (((s_tdata & CONT_BIT) == 8'd0) ||
              (varint_bytes == VB_W'(VARINT_MAX_BYTES - 1))) begin
            push              = 1'b1;
            push_item.kind    = KIND_WORD;
            push_item.slot    = slot_index;
            push_item.val     = acc_new;
            varint_accum_next = '0;
            varint_bytes_next = '0;
            if (slot_index == SLOT_W'(WORDS_PER_RECORD - 1)) begin
              slot_index_next = '0;
              phase_next      = PH_CNT_LO;
            end else begin
              slot_index_next = slot_index + SLOT_W'(1);
            end
          end else begin
            varint_accum_next = acc_new;
            varint_bytes_next = varint_bytes + VB_W'(1);
          end
        end
        PH_CNT_LO: begin
          body               = 1'b1;
          low_byte_hold_next = s_tdata;
          phase_next         = PH_CNT_HI;
        end
        PH_CNT_HI: begin
          body            = 1'b1;
          pairs_left_next = len;
          if (len == 16'd0) begin
            push           = 1'b1;
            push_item.kind = KIND_EMPTY;
            push_item.last = 1'b1;
            done           = 1'b1;
          end else begin
            pair_byte_pos_next = '0;
            phase_next         = PH_PAIR;
          end
        end
        PH_PAIR: begin
          body = 1'b1;
          case (pair_byte_pos)
            2'd0, 2'd2: begin
              low_byte_hold_next = s_tdata;
              pair_byte_pos_next = pair_byte_pos + 2'd1;
            end
            2'd1: begin
              year_hold_next     = len;
              pair_byte_pos_next = 2'd2;
            end
            default: begin
              pairs_left_next    = pairs_dec;
              pair_byte_pos_next = 2'd0;
              done               = (pairs_dec == 16'd0);
              push               = 1'b1;
              push_item.kind     = KIND_PAIR;
              push_item.val      = {3'd0, year_hold, len};
              push_item.last     = done;
            end
          endcase
        end
        default: begin   // length low byte, and the unused phase code
          low_byte_hold_next = s_tdata;
          phase_next         = PH_LEN_HI;
        end
      endcase

      if (body) begin
        bytes_left_next = bl_dec;
        if (done) begin
          phase_next = (bl_dec != 16'd0) ? PH_SKIP : PH_LEN_LO;
        end else if (bl_dec == 16'd0) begin
          // fields ran past the length: error replaces this byte's result
          push           = 1'b1;
          push_item      = '0;
          push_item.kind = KIND_ERROR;
          push_item.last = 1'b1;
          phase_next     = PH_LEN_LO;
        end
      end
    end
  end

endmodule

/* design/nrp_queue.sv */
// ----------------------------------------------------------------------------
// nrp_queue
// Short FIFO of classified results between parser and output stage.
// ----------------------------------------------------------------------------
module nrp_queue #(
  parameter int DEPTH = nrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  nrp_pkg::q_item_t push_item,
  output logic             full,
  output logic             q_valid,
  output nrp_pkg::q_item_t q_item,
  input  logic             pop
);
  import nrp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem [DEPTH];
  logic [AW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   cnt;

  assign full    = (cnt == CW'(DEPTH));
  assign q_valid = (cnt != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      if (pop)  rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      case ({push, pop})
        2'b10:   cnt <= cnt + CW'(1);
        2'b01:   cnt <= cnt - CW'(1);
        default: cnt <= cnt;
      endcase
    end
  end

`include "ngram_record_parser_top_assert.svh"

  `NRP_ASSERT_NOW(a_cnt_bound, 1'b1, cnt <= CW'(DEPTH), "queue count above depth")
  `NRP_ASSERT_NOW(a_no_under, pop, cnt != '0, "pop from empty queue")
  `NRP_ASSERT_NEXT(a_cnt_up, push && !pop, cnt == $past(cnt) + CW'(1), "count lost a push")

endmodule

/* design/nrp_back.sv */
// ----------------------------------------------------------------------------
// nrp_back
// Output stage: finishes each result and holds it on the master channel.
// ----------------------------------------------------------------------------
module nrp_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  nrp_pkg::q_item_t            q_item,
  output logic                        pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [nrp_pkg::TDATA_W-1:0] m_tdata,
  output logic [nrp_pkg::TUSER_W-1:0] m_tuser,
  output logic                        m_tlast
);
  import nrp_pkg::*;

  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0]   word_id;
  logic [HALF_W-1:0] year, count;

  assign pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    slot    = '0;
    word_id = '0;
    year    = '0;
    count   = '0;
    case (q_item.kind)
      KIND_WORD: begin
        slot    = q_item.slot;
        word_id = q_item.val - ID_W'(1);   // ids are stored one-based
      end
      KIND_PAIR: begin
        year  = q_item.val[2*HALF_W-1:HALF_W];
        count = q_item.val[HALF_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (pop) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      m_tdata <= {2'b00, count, year, word_id, slot};
      m_tuser <= q_item.kind;
      m_tlast <= q_item.last;
    end
  end

endmodule

/* design/ngram_record_parser_top.sv */
// ----------------------------------------------------------------------------
// ngram_record_parser_top
// Length-prefixed n-gram record decoder with varint word ids.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : raw record bytes, one byte per beat (s_tdata[7:0] = data_byte).
//   m_* : one result beat per word id, per year/count pair, per empty record
//         end and per framing error. m_tuser is the kind, m_tlast marks the
//         last result of a record (final pair, empty end, error).
//   cfg_*: write of max_record_len; cfg_ready is always high. Write it only
//         while no byte is in flight.
// Throughput: one byte per cycle while the result queue has room; the parser's
//   single state walk takes a byte every cycle it is not stalled, and the
//   four-entry result queue plus the output register absorb receiver stalls.
// Path: a result is written into the result queue at the edge that accepted
//   the byte that produced it, then loaded into the output register once
//   that register is empty or being taken by the receiver.
// Stall: when m_tready is low the output beat holds; once the queue fills,
//   s_tready drops until the receiver takes a beat.
// Reset: rst (synchronous) returns the parser to waiting for a length low
//   byte, empties the queue, drops m_tvalid and sets max_record_len to 16384.
// ----------------------------------------------------------------------------
module ngram_record_parser_top #(
  parameter int WORDS_PER_RECORD = nrp_pkg::WORDS_PER_RECORD_DEF,
  parameter int VARINT_MAX_BYTES = nrp_pkg::VARINT_MAX_BYTES_DEF,
  parameter int QUEUE_DEPTH      = nrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // byte stream in
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,    // [7:0] data_byte
  // results out
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [nrp_pkg::TDATA_W-1:0] m_tdata,    // [2:0] word_slot, [37:3] word_id,
                                                  // [53:38] year, [69:54] count,
                                                  // [71:70] zero
  output logic [nrp_pkg::TUSER_W-1:0] m_tuser,    // [1:0] kind
  output logic                        m_tlast,    // last_of_record
  // max_record_len write
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [nrp_pkg::CFG_W-1:0]   cfg_data    // [15:0] max_record_len
);
  import nrp_pkg::*;

  logic    push, q_full, q_valid, pop;
  q_item_t push_item, q_item;

  // register write never stalls
  assign cfg_ready = 1'b1;

  // front: framing state machine, classifies each byte
  nrp_front #(
    .WORDS_PER_RECORD (WORDS_PER_RECORD),
    .VARINT_MAX_BYTES (VARINT_MAX_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // decoupling queue
  nrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .pop       (pop)
  );

  // back: id offset, field zeroing, output register
  nrp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

/* sim/tb_ngram_record_parser_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ngram_record_parser_top
// Self-checking bench for the n-gram record parser: a byte-level model
// predicts every result beat, and both stream sides idle at random.
// ----------------------------------------------------------------------------
module tb_ngram_record_parser_top;
  import nrp_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int DIRECTED_ROWS = 34;
  localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
  localparam int HOLD_AT_BYTE  = 150;   // byte count that triggers it
  localparam int SETTLE_CYCLES = 8;     // queue and output register drain, plus margin

  // one result beat, unpacked from m_tuser/m_tdata/m_tlast
  typedef struct packed {
    kind_t       kind;
    logic [2:0]  slot;
    logic [34:0] id;
    logic [15:0] year;
    logic [15:0] count;
    logic        last;
  } parse_result_t;

  // directed row: a byte and, where obvious, its hand-written result
  typedef struct packed {
    logic [7:0]    data;
    logic          typed;
    parse_result_t res;
  } stim_row_t;

  localparam parse_result_t NO_RES  = '0;
  localparam parse_result_t ERR_RES = '{KIND_ERROR, 3'd0, 35'd0, 16'd0, 16'd0, 1'b1};
  localparam parse_result_t END_RES = '{KIND_EMPTY, 3'd0, 35'd0, 16'd0, 16'd0, 1'b1};

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'h00;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [TDATA_W-1:0]   m_tdata;
  logic [TUSER_W-1:0]   m_tuser;
  logic                 m_tlast;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data = '0;

  // expectations, oldest first
  parse_result_t pending_results[$];

  int unsigned cycles = 0;
  int unsigned bytes_in = 0;
  int unsigned beats_out = 0;
  int unsigned n_fail = 0;
  int unsigned kind_seen[4] = '{0, 0, 0, 0};
  bit          steady = 1'b0;     // no idling on either side while set
  bit          hold_done = 1'b0;
  int          hold_left = 0;

  // parser model state, mirrors the block after reset
  phase_t      rec_phase = PH_LEN_LO;
  logic [15:0] rec_left = '0;
  logic [7:0]  lo_hold = '0;
  logic [34:0] id_acc = '0;
  int          id_bytes = 0;
  int          word_slot = 0;
  logic [15:0] pairs_left = '0;
  logic [15:0] year_hold = '0;
  int          pair_pos = 0;
  logic [15:0] max_len = MAX_LEN_RESET;

  // Directed bytes: zero length, a full record with extreme varints and an
  // all-ones pair plus one skipped trailing byte, a record with no pairs,
  // and a record whose fields run past its length after the second word.
  stim_row_t directed_tab [DIRECTED_ROWS] = '{
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, ERR_RES},                        // zero-length body
    '{8'h11, 1'b0, NO_RES},                         // body length 17
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, '{KIND_WORD, 3'd0, 35'h7_FFFF_FFFF, 16'd0, 16'd0, 1'b0}},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{KIND_WORD, 3'd1, 35'h7_FFFF_FFFE, 16'd0, 16'd0, 1'b0}},
    '{8'h81, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h7F, 1'b0, NO_RES},
    '{8'h01, 1'b1, '{KIND_WORD, 3'd4, 35'd0, 16'd0, 16'd0, 1'b0}},
    '{8'h01, 1'b0, NO_RES},                         // one pair
    '{8'h00, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b0, NO_RES},
    '{8'hFF, 1'b1, '{KIND_PAIR, 3'd0, 35'd0, 16'hFFFF, 16'hFFFF, 1'b1}},
    '{8'hAB, 1'b0, NO_RES},                         // leftover, skipped
    '{8'h07, 1'b0, NO_RES},                         // body length 7
    '{8'h00, 1'b0, NO_RES},
    '{8'h02, 1'b0, NO_RES},
    '{8'h03, 1'b0, NO_RES},
    '{8'h04, 1'b0, NO_RES},
    '{8'h05, 1'b0, NO_RES},
    '{8'h06, 1'b0, NO_RES},
    '{8'h00, 1'b0, NO_RES},
    '{8'h00, 1'b1, END_RES},                        // zero pairs
    '{8'h02, 1'b0, NO_RES},                         // body length 2
    '{8'h00, 1'b0, NO_RES},
    '{8'h05, 1'b0, NO_RES},
    '{8'h06, 1'b1, ERR_RES}                         // fields run past body
  };

  ngram_record_parser_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
  end

  // Byte-level model of the parser. Returns at most one result per byte;
  // a run-past error replaces whatever the byte would otherwise give.
  task automatic parse_byte(input logic [7:0] b, output bit got, output parse_result_t r);
    logic [15:0] len;
    bit          done;
    got = 1'b0;
    done = 1'b0;
    r = NO_RES;
    case (rec_phase)
      PH_LEN_HI: begin
        len = {b, lo_hold};
        if (len > max_len) begin
          r = ERR_RES;
          got = 1'b1;
          rec_left = len;
          rec_phase = (len != 0) ? PH_SKIP : PH_LEN_LO;
        end else if (len == 0) begin
          r = ERR_RES;
          got = 1'b1;
          rec_left = '0;
          rec_phase = PH_LEN_LO;
        end else begin
          rec_left = len;
          id_acc = '0;
          id_bytes = 0;
          word_slot = 0;
          pair_pos = 0;
          rec_phase = PH_WORD;
        end
      end
      PH_SKIP: begin
        rec_left = rec_left - 16'd1;
        if (rec_left == 0) rec_phase = PH_LEN_LO;
      end
      PH_WORD, PH_CNT_LO, PH_CNT_HI, PH_PAIR: begin
        rec_left = rec_left - 16'd1;
        if (rec_phase == PH_WORD) begin
          id_acc = {id_acc[27:0], b[6:0] & PAYLOAD_MASK[6:0]};
          if ((b & CONT_BIT) == 0 || id_bytes + 1 >= VARINT_MAX_BYTES_DEF) begin
            r = '{KIND_WORD, word_slot[2:0], id_acc - 35'd1, 16'd0, 16'd0, 1'b0};
            got = 1'b1;
            id_acc = '0;
            id_bytes = 0;
            if (word_slot + 1 >= WORDS_PER_RECORD_DEF) begin
              word_slot = 0;
              rec_phase = PH_CNT_LO;
            end else begin
              word_slot++;
            end
          end else begin
            id_bytes++;
          end
        end else if (rec_phase == PH_CNT_LO) begin
          lo_hold = b;
          rec_phase = PH_CNT_HI;
        end else if (rec_phase == PH_CNT_HI) begin
          pairs_left = {b, lo_hold};
          if (pairs_left == 0) begin
            r = END_RES;
            got = 1'b1;
            done = 1'b1;
          end else begin
            pair_pos = 0;
            rec_phase = PH_PAIR;
          end
        end else begin
          if (pair_pos == 0 || pair_pos == 2) begin
            lo_hold = b;
            pair_pos++;
          end else if (pair_pos == 1) begin
            year_hold = {b, lo_hold};
            pair_pos = 2;
          end else begin
            pairs_left = pairs_left - 16'd1;
            pair_pos = 0;
            done = (pairs_left == 0);
            r = '{KIND_PAIR, 3'd0, 35'd0, year_hold, {b, lo_hold}, done};
            got = 1'b1;
          end
        end
        if (done) begin
          rec_phase = (rec_left != 0) ? PH_SKIP : PH_LEN_LO;
        end else if (rec_left == 0) begin
          r = ERR_RES;
          got = 1'b1;
          rec_phase = PH_LEN_LO;
        end
      end
      default: begin
        lo_hold = b;
        rec_phase = PH_LEN_HI;
      end
    endcase
  endtask

  // Offer one byte, idling at random first; predict at the accepting edge.
  // A typed row queues its hand-written result instead of the model's.
  task automatic send_byte(input logic [7:0] b, input bit typed, input parse_result_t want);
    bit            got;
    parse_result_t r;
    while (!steady && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk); while (!s_tready);
    bytes_in++;
    parse_byte(b, got, r);
    if (typed) pending_results.push_back(want);
    else if (got) pending_results.push_back(r);
  endtask

  // One framed record: mostly well formed with random content, the rest
  // truncated bodies, zero lengths, over-limit lengths and random bodies.
  task automatic send_record();
    logic [7:0]  body[$];
    logic [7:0]  v;
    logic [15:0] len;
    int          style, nb, npairs;
    bit          stuck;
    style = $urandom_range(0, 99);
    if (style < 80) begin
      for (int w = 0; w < WORDS_PER_RECORD_DEF; w++) begin
        nb = ($urandom_range(0, 7) == 0) ? VARINT_MAX_BYTES_DEF : $urandom_range(1, 3);
        // a five-byte id that still says "more follows" is cut off anyway
        stuck = (nb == VARINT_MAX_BYTES_DEF) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < nb; i++) begin
          v = 8'($urandom_range(0, 127));
          if (i < nb - 1 || stuck) v = v | CONT_BIT;
          body.push_back(v);
        end
      end
      npairs = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4);
      body.push_back(npairs[7:0]);
      body.push_back(8'h00);
      repeat (4 * npairs) body.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) body.push_back(8'($urandom_range(0, 255)));
      len = 16'(body.size());
      if (style >= 65) begin
        // body cut short: fields run past the length
        len = 16'($urandom_range(1, body.size() - 1));
        while (body.size() > len) void'(body.pop_back());
      end
    end else if (style < 88) begin
      len = '0;
    end else begin
      // past the limit when it is small, otherwise a random body
      len = (max_len < 48) ? max_len + 16'($urandom_range(1, 8))
                           : 16'($urandom_range(0, 48));
      repeat (len) body.push_back(8'($urandom_range(0, 255)));
    end
    send_byte(len[7:0], 1'b0, NO_RES);
    send_byte(len[15:8], 1'b0, NO_RES);
    foreach (body[i]) send_byte(body[i], 1'b0, NO_RES);
  endtask

  // Park the input, let every expected beat come out, then allow the
  // pipeline to settle in case a byte with no result is still inside.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len = value;
  endtask

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  // Receiver: check each accepted beat, then pick the next m_tready.
  // Once, mid-run, it holds off long enough for the input to back up.
  initial begin
    parse_result_t seen, want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        seen = '{kind_t'(m_tuser), m_tdata[2:0], m_tdata[37:3], m_tdata[53:38],
                 m_tdata[69:54], m_tlast};
        beats_out++;
        kind_seen[seen.kind]++;
        if (pending_results.size() == 0) begin
          $error("result beat with nothing expected, kind %0d", seen.kind);
          n_fail++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", want.kind, seen.kind);
          check_field("word_slot", want.slot, seen.slot);
          check_field("word_id", want.id, seen.id);
          check_field("year", want.year, seen.year);
          check_field("count", want.count, seen.count);
          check_field("last_of_record", want.last, seen.last);
        end
      end
      if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= steady || ($urandom_range(0, 99) >= 25);
      end
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $error("timeout after %0d cycles, %0d results outstanding", cycles,
           pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset limit: directed table, then random records
    for (int i = 0; i < DIRECTED_ROWS; i++)
      send_byte(directed_tab[i].data, directed_tab[i].typed, directed_tab[i].res);
    while (bytes_in < 250) send_record();

    // limit of one: every real record errors out
    write_max_len(16'd1);
    while (bytes_in < 310) send_record();

    // limit of zero: every nonzero length is over the limit
    write_max_len(16'd0);
    while (bytes_in < 350) send_record();

    // largest limit, with both sides running flat out
    write_max_len(16'hFFFF);
    steady = 1'b1;
    while (bytes_in < 550) send_record();
    steady = 1'b0;

    // small random limit: a mix of parsed and skipped records
    write_max_len(16'($urandom_range(8, 40)));
    while (bytes_in < 700) send_record();

    wait_idle();
    $display("%0d bytes in, %0d result beats checked over five length limits",
             bytes_in, beats_out);
    $display("beats by kind: word %0d, pair %0d, empty end %0d, error %0d",
             kind_seen[KIND_WORD], kind_seen[KIND_PAIR], kind_seen[KIND_EMPTY],
             kind_seen[KIND_ERROR]);
    if (n_fail == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
